### rtl/tssc_pkg.sv
`timescale 1ns / 1ps

package tssc_pkg;

    // Default geometry
    localparam int SAMPLE_WIDTH_DEF = 24;
    localparam int COUNT_WIDTH_DEF  = 28;

    // Configuration register widths
    localparam int HP_W = 27;
    localparam int FL_W = 16;
    localparam int FR_W = 25;

    // Reset values of the configuration registers
    localparam logic [HP_W-1:0] HALF_PERIOD_RST = HP_W'(2880000);
    localparam logic [FL_W-1:0] FADE_LEN_RST    = FL_W'(4800);
    localparam logic [FR_W-1:0] FADE_RECIP_RST  = FR_W'(3495);

    // Q1.16 fade weight, saturated to one
    localparam int W_FRAC = 16;
    localparam int W_W    = W_FRAC + 1;
    localparam logic [W_W-1:0] W_ONE = W_W'(65536);

    // Weight product is shifted down by this before saturation
    localparam int RECIP_SHIFT = 8;

    // APB register map
    localparam int ADDR_W = 4;
    localparam int APB_DW = 32;

    typedef enum logic [1:0] {
        REG_HALF_PERIOD = 2'd0,
        REG_FADE_LEN    = 2'd1,
        REG_FADE_RECIP  = 2'd2
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRAP,
        ST_PHASE,
        ST_MUL_OFF,
        ST_SAT,
        ST_MUL_W,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic accept;
        logic wrap;
        logic phase;
        logic mul_off;
        logic sat;
        logic mul_w;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

endpackage

### rtl/tssc_ctrl.sv
`timescale 1ns / 1ps

module tssc_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  tssc_pkg::status_t   status,
    output tssc_pkg::cmd_t      cmd
);

    tssc_pkg::state_t state_reg;
    tssc_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tssc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tssc_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = tssc_pkg::ST_WRAP;
                end
            end
            tssc_pkg::ST_WRAP:    state_next = tssc_pkg::ST_PHASE;
            tssc_pkg::ST_PHASE:   state_next = tssc_pkg::ST_MUL_OFF;
            tssc_pkg::ST_MUL_OFF: state_next = tssc_pkg::ST_SAT;
            tssc_pkg::ST_SAT:     state_next = tssc_pkg::ST_MUL_W;
            tssc_pkg::ST_MUL_W:   state_next = tssc_pkg::ST_FIN;
            tssc_pkg::ST_FIN: begin
                // hold until the output register can take the item
                if (status.out_free) begin
                    state_next = tssc_pkg::ST_IDLE;
                end
            end
            default:              state_next = tssc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            tssc_pkg::ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            tssc_pkg::ST_WRAP:    cmd.wrap    = 1'b1;
            tssc_pkg::ST_PHASE:   cmd.phase   = 1'b1;
            tssc_pkg::ST_MUL_OFF: cmd.mul_off = 1'b1;
            tssc_pkg::ST_SAT:     cmd.sat     = 1'b1;
            tssc_pkg::ST_MUL_W:   cmd.mul_w   = 1'b1;
            tssc_pkg::ST_FIN:     cmd.load_out = status.out_free;
            default: begin
                cmd      = '0;
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

### rtl/tssc_dpath.sv
`timescale 1ns / 1ps

module tssc_dpath #(
    parameter int SAMPLE_WIDTH = tssc_pkg::SAMPLE_WIDTH_DEF,
    parameter int COUNT_WIDTH  = tssc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  tssc_pkg::cmd_t                cmd,
    output tssc_pkg::status_t             status,
    input  logic [tssc_pkg::HP_W-1:0]     half_period,
    input  logic [tssc_pkg::FL_W-1:0]     fade_len,
    input  logic [tssc_pkg::FR_W-1:0]     fade_recip,
    input  logic signed [SAMPLE_WIDTH-1:0] left_in,
    input  logic signed [SAMPLE_WIDTH-1:0] right_in,
    output logic signed [SAMPLE_WIDTH-1:0] left_out,
    output logic signed [SAMPLE_WIDTH-1:0] right_out,
    output logic                          out_valid,
    input  logic                          out_ready
);

    localparam int SW    = SAMPLE_WIDTH;
    localparam int DW    = SW + 1;
    localparam int RB_W  = tssc_pkg::FR_W + 1;
    localparam int BW    = (DW > RB_W) ? DW : RB_W;
    localparam int PW    = BW + tssc_pkg::W_W + 1;
    localparam int SH_W  = PW - tssc_pkg::RECIP_SHIFT;
    localparam int HP2_W = tssc_pkg::HP_W + 1;
    localparam int CMP_W = (COUNT_WIDTH > HP2_W) ? COUNT_WIDTH : HP2_W;

    logic signed [SW-1:0]      left_reg;
    logic signed [SW-1:0]      right_reg;
    logic signed [DW-1:0]      diff_reg;
    logic [COUNT_WIDTH-1:0]    tick_reg;
    logic                      second_reg;
    logic [CMP_W-1:0]          off_reg;
    logic                      fade_reg;
    logic signed [PW-1:0]      mul_reg;
    logic [tssc_pkg::W_W-1:0]  w_reg;
    logic signed [SW-1:0]      left_out_reg;
    logic signed [SW-1:0]      right_out_reg;
    logic                      out_valid_reg;

    logic [CMP_W-1:0]          tick_ext;
    logic [CMP_W-1:0]          hp_ext;
    logic [CMP_W-1:0]          twice_hp;
    logic [tssc_pkg::W_W-1:0]  mul_a;
    logic signed [BW-1:0]      mul_b;
    logic signed [PW-1:0]      mul_full;
    logic [SH_W-1:0]           w_raw;
    logic signed [DW-1:0]      left_ext;
    logic signed [DW-1:0]      right_ext;
    logic signed [DW-1:0]      q_floor;
    logic signed [DW-1:0]      q_carry;
    logic signed [DW-1:0]      sum_up;
    logic signed [DW-1:0]      sum_down;

    assign tick_ext = CMP_W'(tick_reg);
    assign hp_ext   = CMP_W'(half_period);
    assign twice_hp = CMP_W'({half_period, 1'b0});

    // Shared multiplier: offset * reciprocal, then weight * difference
    always_comb begin
        if (cmd.mul_w) begin
            mul_a = w_reg;
            mul_b = BW'(diff_reg);
        end else begin
            mul_a = tssc_pkg::W_W'(off_reg[tssc_pkg::FL_W-1:0]);
            mul_b = BW'($signed({1'b0, fade_recip}));
        end
    end

    assign mul_full = $signed({1'b0, mul_a}) * mul_b;
    assign w_raw    = mul_reg[PW-1:tssc_pkg::RECIP_SHIFT];

    // floor(w*d) and floor(-w*d) share one product: the second is -floor - (fraction != 0)
    assign left_ext  = {left_reg[SW-1], left_reg};
    assign right_ext = {right_reg[SW-1], right_reg};
    assign q_floor   = mul_reg[tssc_pkg::W_FRAC +: DW];
    assign q_carry   = $signed(DW'(|mul_reg[tssc_pkg::W_FRAC-1:0]));
    assign sum_up    = right_ext + q_floor;
    assign sum_down  = left_ext - q_floor - q_carry;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg <= '0;
        end else if (cmd.accept) begin
            tick_reg <= tick_reg + COUNT_WIDTH'(1);
        end else if (cmd.wrap && (tick_ext > twice_hp)) begin
            tick_reg <= '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            left_reg  <= left_in;
            right_reg <= right_in;
            diff_reg  <= {left_in[SW-1], left_in} - {right_in[SW-1], right_in};
        end
        if (cmd.phase) begin
            second_reg <= (tick_ext >= hp_ext);
            off_reg    <= (tick_ext >= hp_ext) ? (tick_ext - hp_ext) : tick_ext;
        end
        if (cmd.mul_off) begin
            fade_reg <= (off_reg < CMP_W'(fade_len));
        end
        if (cmd.mul_off || cmd.mul_w) begin
            mul_reg <= mul_full;
        end
        if (cmd.sat) begin
            // outside the fade the full weight gives the settled routing
            if (!fade_reg || (w_raw > SH_W'(tssc_pkg::W_ONE))) begin
                w_reg <= tssc_pkg::W_ONE;
            end else begin
                w_reg <= w_raw[tssc_pkg::W_W-1:0];
            end
        end
        if (cmd.load_out) begin
            if (second_reg) begin
                left_out_reg  <= sum_down[SW-1:0];
                right_out_reg <= sum_up[SW-1:0];
            end else begin
                left_out_reg  <= sum_up[SW-1:0];
                right_out_reg <= sum_down[SW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign left_out        = left_out_reg;
    assign right_out       = right_out_reg;
    assign out_valid       = out_valid_reg;

endmodule

### rtl/timed_stereo_swap_crossfader.sv
`timescale 1ns / 1ps

// Timed stereo swap crossfader.
// Input stream (s_*): one stereo pair per item, left_in in the low bits of
// s_tdata and right_in above it. Output stream (m_*): one pair per input
// item, same layout. A tick counter advances per item; in the first half of
// each period the pair fades from swapped to direct over fade_len items, in
// the second half from direct to swapped. Registers half_period, fade_len and
// fade_recip sit on the APB port at byte addresses 0, 4 and 8.
// One item is taken at a time and its result is registered in the output
// register; a single multiplier is shared by the weight product and the blend
// product, and the controller walks one item through wrap, phase, offset
// multiply, saturation, blend multiply and output.
// A result waits in the output register while the next item is taken in;
// if the receiver stalls long enough, the controller holds in its last step
// and s_tready stays low until the output register frees.
// Reset (aresetn, synchronous, active low) clears the tick counter and the
// stream control and restores the register defaults; no clearing pass.
module timed_stereo_swap_crossfader #(
    parameter int SAMPLE_WIDTH = tssc_pkg::SAMPLE_WIDTH_DEF,
    parameter int COUNT_WIDTH  = tssc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [SAMPLE_WIDTH-1:0] left_in, [2*SAMPLE_WIDTH-1:SAMPLE_WIDTH] right_in, zero pad
    input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [SAMPLE_WIDTH-1:0] left_out, [2*SAMPLE_WIDTH-1:SAMPLE_WIDTH] right_out, zero pad
    output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] m_tdata,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tssc_pkg::ADDR_W-1:0]       paddr,
    input  logic [tssc_pkg::APB_DW-1:0]       pwdata,
    output logic [tssc_pkg::APB_DW-1:0]       prdata,
    output logic                              pready
);

    localparam int SW     = SAMPLE_WIDTH;
    localparam int TD_W   = ((2*SW+7)/8)*8;
    localparam int PAD_W  = TD_W - 2*SW;

    logic [tssc_pkg::HP_W-1:0] half_period_reg;
    logic [tssc_pkg::FL_W-1:0] fade_len_reg;
    logic [tssc_pkg::FR_W-1:0] fade_recip_reg;
    tssc_pkg::reg_idx_t        reg_idx;
    logic                      wr_en;

    tssc_pkg::cmd_t            cmd;
    tssc_pkg::status_t         status;
    logic signed [SW-1:0]      left_out;
    logic signed [SW-1:0]      right_out;

    assign pready  = 1'b1;
    assign reg_idx = tssc_pkg::reg_idx_t'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_period_reg <= tssc_pkg::HALF_PERIOD_RST;
            fade_len_reg    <= tssc_pkg::FADE_LEN_RST;
            fade_recip_reg  <= tssc_pkg::FADE_RECIP_RST;
        end else if (wr_en) begin
            case (reg_idx)
                tssc_pkg::REG_HALF_PERIOD: half_period_reg <= pwdata[tssc_pkg::HP_W-1:0];
                tssc_pkg::REG_FADE_LEN:    fade_len_reg    <= pwdata[tssc_pkg::FL_W-1:0];
                tssc_pkg::REG_FADE_RECIP:  fade_recip_reg  <= pwdata[tssc_pkg::FR_W-1:0];
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            tssc_pkg::REG_HALF_PERIOD: prdata = tssc_pkg::APB_DW'(half_period_reg);
            tssc_pkg::REG_FADE_LEN:    prdata = tssc_pkg::APB_DW'(fade_len_reg);
            tssc_pkg::REG_FADE_RECIP:  prdata = tssc_pkg::APB_DW'(fade_recip_reg);
            default:                   prdata = '0;
        endcase
    end

    tssc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tssc_dpath #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .half_period (half_period_reg),
        .fade_len    (fade_len_reg),
        .fade_recip  (fade_recip_reg),
        .left_in     (s_tdata[SW-1:0]),
        .right_in    (s_tdata[2*SW-1:SW]),
        .left_out    (left_out),
        .right_out   (right_out),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready)
    );

    generate
        if (PAD_W > 0) begin : g_pad
            assign m_tdata = {{PAD_W{1'b0}}, right_out, left_out};
        end else begin : g_nopad
            assign m_tdata = {right_out, left_out};
        end
    endgenerate

endmodule

### rtl/tssc_checker.sv
`timescale 1ns / 1ps

module tssc_checker #(
    parameter int SAMPLE_WIDTH = tssc_pkg::SAMPLE_WIDTH_DEF
) (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] m_tdata,
    input logic                                pready
);

    // reset empties the output register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // one item at a time: an accepted item closes the input side
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while an item is in flight");

    // a new result is loaded only from the busy controller
    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared without an item in flight");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("pready low");

endmodule

bind timed_stereo_swap_crossfader tssc_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_tssc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .pready   (pready)
);
